/* rtl/bldq_pkg.sv */
// Package for the bounded list deque engine: sizes, request and status codes,
// and the ring slot helper. No dependencies.
`timescale 1ns / 1ps

package bldq_pkg;

    localparam int DEPTH  = 64;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 6;
    localparam int REQ_W  = 4;
    localparam int STAT_W = 2;
    localparam int CNT_OUT_W = 7;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd3;
    localparam logic [REQ_W-1:0] REQ_CONTAINS   = 4'd4;
    localparam logic [REQ_W-1:0] REQ_READ       = 4'd5;
    localparam logic [REQ_W-1:0] REQ_WRITE      = 4'd6;
    localparam logic [REQ_W-1:0] REQ_FIRST_GT   = 4'd7;
    localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd8;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADIDX = 2'd3;

    // Physical slot of list index idx: (head + idx) mod DEPTH, idx <= DEPTH.
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                  input logic [CNT_W-1:0] idx);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(idx);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

/* rtl/bldq_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bldq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/bounded_list_deque_engine.sv */
// Bounded double-ended queue of signed 32-bit values held in one ring RAM.
// Depends on bldq_pkg and bldq_ram.
//
//  channel | signals                                              | direction
//  --------+------------------------------------------------------+----------
//  request | in_valid, in_ready, req_type, operand_value,         | in
//          | position_in                                          |
//  result  | out_valid, out_ready, read_value, hit, position_out, | out
//          | status, entry_count                                  |
//
// One item at a time. Push, pop, write and clear pass through the execute and finish states;
// read adds a RAM read wait state; contains and first greater skip the scan when empty, else
// scan one stored entry per cycle through the RAM read port, stopping early on a hit.
// Reset empties the list at once; RAM contents are left undefined.
// A result waiting on out_ready holds the engine in its final state.
`timescale 1ns / 1ps

module bounded_list_deque_engine (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [bldq_pkg::REQ_W-1:0]           req_type,
    input  logic signed [bldq_pkg::VAL_W-1:0]    operand_value,
    input  logic [bldq_pkg::POS_W-1:0]           position_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [bldq_pkg::VAL_W-1:0]    read_value,
    output logic                                 hit,
    output logic [bldq_pkg::POS_W-1:0]           position_out,
    output logic [bldq_pkg::STAT_W-1:0]          status,
    output logic [bldq_pkg::CNT_OUT_W-1:0]       entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RDWAIT,
        S_SCAN,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [bldq_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [bldq_pkg::CNT_W-1:0]  count_reg, count_next;

    logic [bldq_pkg::REQ_W-1:0]        req_reg, req_next;
    logic signed [bldq_pkg::VAL_W-1:0] op_reg, op_next;
    logic [bldq_pkg::POS_W-1:0]        pos_reg, pos_next;

    // scan: iss = index being fetched, cmp = index whose data is at the RAM output
    logic [bldq_pkg::CNT_W-1:0] iss_reg, iss_next;
    logic [bldq_pkg::CNT_W-1:0] cmp_reg, cmp_next;

    logic [bldq_pkg::VAL_W-1:0]  res_rd_reg, res_rd_next;
    logic                        res_hit_reg, res_hit_next;
    logic [bldq_pkg::POS_W-1:0]  res_pos_reg, res_pos_next;
    logic [bldq_pkg::STAT_W-1:0] res_st_reg, res_st_next;

    logic                            out_valid_reg, out_valid_next;
    logic [bldq_pkg::VAL_W-1:0]      read_value_reg, read_value_next;
    logic                            hit_reg, hit_next;
    logic [bldq_pkg::POS_W-1:0]      position_out_reg, position_out_next;
    logic [bldq_pkg::STAT_W-1:0]     status_reg, status_next;
    logic [bldq_pkg::CNT_OUT_W-1:0]  entry_count_reg, entry_count_next;

    logic                        ram_we;
    logic [bldq_pkg::ADDR_W-1:0] ram_waddr;
    logic [bldq_pkg::VAL_W-1:0]  ram_wdata;
    logic [bldq_pkg::ADDR_W-1:0] ram_raddr;
    logic [bldq_pkg::VAL_W-1:0]  ram_rdata;

    logic                        full;
    logic                        empty;
    logic                        pos_bad;
    logic [bldq_pkg::CNT_W-1:0]  pos_idx;
    logic                        match;
    logic                        out_free;

    bldq_ram #(
        .WIDTH (bldq_pkg::VAL_W),
        .DEPTH (bldq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign full     = (count_reg == bldq_pkg::CNT_W'(bldq_pkg::DEPTH));
    assign empty    = (count_reg == '0);
    assign pos_bad  = (bldq_pkg::CMP_W'(pos_reg) >= bldq_pkg::CMP_W'(count_reg));
    assign pos_idx  = bldq_pkg::CNT_W'(bldq_pkg::CMP_W'(pos_reg));
    assign out_free = !out_valid_reg || out_ready;

    assign match = (req_reg == bldq_pkg::REQ_CONTAINS) ? (ram_rdata == op_reg)
                                                       : ($signed(ram_rdata) > op_reg);

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        req_next          = req_reg;
        op_next           = op_reg;
        pos_next          = pos_reg;
        iss_next          = iss_reg;
        cmp_next          = cmp_reg;
        res_rd_next       = res_rd_reg;
        res_hit_next      = res_hit_reg;
        res_pos_next      = res_pos_reg;
        res_st_next       = res_st_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        read_value_next   = read_value_reg;
        hit_next          = hit_reg;
        position_out_next = position_out_reg;
        status_next       = status_reg;
        entry_count_next  = entry_count_reg;
        ram_we            = 1'b0;
        ram_waddr         = head_reg;
        ram_wdata         = op_reg;
        ram_raddr         = bldq_pkg::slot_of(head_reg, iss_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next   = req_type;
                    op_next    = operand_value;
                    pos_next   = position_in;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_rd_next  = '0;
                res_hit_next = 1'b0;
                res_pos_next = '0;
                res_st_next  = bldq_pkg::ST_OK;
                state_next   = S_FIN;
                unique case (req_reg)
                    bldq_pkg::REQ_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            res_st_next = bldq_pkg::ST_FULL;
                        end
                        else
                        begin
                            head_next = (head_reg == '0)
                                ? bldq_pkg::ADDR_W'(bldq_pkg::DEPTH - 1)
                                : head_reg - 1'b1;
                            ram_we     = 1'b1;
                            ram_waddr  = head_next;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    bldq_pkg::REQ_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            res_st_next = bldq_pkg::ST_FULL;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = bldq_pkg::slot_of(head_reg, count_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    bldq_pkg::REQ_POP_FRONT:
                    begin
                        if (empty)
                        begin
                            res_st_next = bldq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            head_next  = bldq_pkg::slot_of(head_reg, bldq_pkg::CNT_W'(1));
                            count_next = count_reg - 1'b1;
                        end
                    end
                    bldq_pkg::REQ_POP_BACK:
                    begin
                        if (empty)
                        begin
                            res_st_next = bldq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    bldq_pkg::REQ_CONTAINS, bldq_pkg::REQ_FIRST_GT:
                    begin
                        if (!empty)
                        begin
                            ram_raddr  = bldq_pkg::slot_of(head_reg, '0);
                            iss_next   = bldq_pkg::CNT_W'(1);
                            cmp_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    bldq_pkg::REQ_READ:
                    begin
                        if (pos_bad)
                        begin
                            res_st_next = bldq_pkg::ST_BADIDX;
                        end
                        else
                        begin
                            ram_raddr  = bldq_pkg::slot_of(head_reg, pos_idx);
                            state_next = S_RDWAIT;
                        end
                    end
                    bldq_pkg::REQ_WRITE:
                    begin
                        if (pos_bad)
                        begin
                            res_st_next = bldq_pkg::ST_BADIDX;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = bldq_pkg::slot_of(head_reg, pos_idx);
                        end
                    end
                    bldq_pkg::REQ_CLEAR:
                    begin
                        head_next  = '0;
                        count_next = '0;
                    end
                    default:
                    begin
                        // unused codes: no change
                    end
                endcase
            end
            S_RDWAIT:
            begin
                res_rd_next = ram_rdata;
                state_next  = S_FIN;
            end
            S_SCAN:
            begin
                // fetch of the next entry overlaps the compare of this one
                iss_next = iss_reg + 1'b1;
                cmp_next = cmp_reg + 1'b1;
                if (match)
                begin
                    res_hit_next = 1'b1;
                    res_pos_next = (req_reg == bldq_pkg::REQ_FIRST_GT)
                                   ? bldq_pkg::POS_W'(cmp_reg) : '0;
                    state_next   = S_FIN;
                end
                else if (cmp_reg + 1'b1 == count_reg)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    read_value_next   = res_rd_reg;
                    hit_next          = res_hit_reg;
                    position_out_next = res_pos_reg;
                    status_next       = res_st_reg;
                    entry_count_next  = bldq_pkg::CNT_OUT_W'(count_reg);
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            head_reg         <= '0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
            req_reg          <= '0;
            op_reg           <= '0;
            pos_reg          <= '0;
            iss_reg          <= '0;
            cmp_reg          <= '0;
            res_rd_reg       <= '0;
            res_hit_reg      <= 1'b0;
            res_pos_reg      <= '0;
            res_st_reg       <= bldq_pkg::ST_OK;
            read_value_reg   <= '0;
            hit_reg          <= 1'b0;
            position_out_reg <= '0;
            status_reg       <= bldq_pkg::ST_OK;
            entry_count_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            out_valid_reg    <= out_valid_next;
            req_reg          <= req_next;
            op_reg           <= op_next;
            pos_reg          <= pos_next;
            iss_reg          <= iss_next;
            cmp_reg          <= cmp_next;
            res_rd_reg       <= res_rd_next;
            res_hit_reg      <= res_hit_next;
            res_pos_reg      <= res_pos_next;
            res_st_reg       <= res_st_next;
            read_value_reg   <= read_value_next;
            hit_reg          <= hit_next;
            position_out_reg <= position_out_next;
            status_reg       <= status_next;
            entry_count_reg  <= entry_count_next;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign read_value   = read_value_reg;
    assign hit          = hit_reg;
    assign position_out = position_out_reg;
    assign status       = status_reg;
    assign entry_count  = entry_count_reg;

endmodule

/* tb/testbench.sv */
// Testbench for bounded_list_deque_engine: directed edge cases, a full-ring pass and a long
// random mix, each result checked against a ring-buffer predictor kept in this file.
// Depends on bldq_pkg and the engine RTL.
`timescale 1ns / 1ps

module testbench;

    localparam logic [bldq_pkg::REQ_W-1:0] REQ_FIRST_UNUSED = 4'd9;
    localparam logic [bldq_pkg::REQ_W-1:0] REQ_LAST_UNUSED  = 4'd15;
    localparam logic signed [bldq_pkg::VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [bldq_pkg::VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic signed [bldq_pkg::VAL_W-1:0] value;
        logic                              found;
        logic [bldq_pkg::POS_W-1:0]        where;
        logic [bldq_pkg::STAT_W-1:0]       code;
        logic [bldq_pkg::CNT_OUT_W-1:0]    held;
    } deque_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [bldq_pkg::REQ_W-1:0]         req_type = '0;
    logic signed [bldq_pkg::VAL_W-1:0]  operand_value = '0;
    logic [bldq_pkg::POS_W-1:0]         position_in = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [bldq_pkg::VAL_W-1:0]  read_value;
    logic                               hit;
    logic [bldq_pkg::POS_W-1:0]         position_out;
    logic [bldq_pkg::STAT_W-1:0]        status;
    logic [bldq_pkg::CNT_OUT_W-1:0]     entry_count;

    // predictor state
    logic signed [bldq_pkg::VAL_W-1:0]  list_store [bldq_pkg::DEPTH];
    int                                 list_head = 0;
    int                                 list_count = 0;

    deque_result_t            pending_results [$];
    int                       error_count = 0;
    int                       requests_sent = 0;
    int                       results_checked = 0;
    int                       full_visits = 0;
    int                       empty_rejects = 0;
    bit                       steady_run = 1'b0;

    bounded_list_deque_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .operand_value (operand_value),
        .position_in   (position_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_value    (read_value),
        .hit           (hit),
        .position_out  (position_out),
        .status        (status),
        .entry_count   (entry_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int ring_slot(input int idx);
        return (list_head + idx) % bldq_pkg::DEPTH;
    endfunction

    function automatic deque_result_t apply_request(
        input logic [bldq_pkg::REQ_W-1:0] kind,
        input logic signed [bldq_pkg::VAL_W-1:0] operand,
        input logic [bldq_pkg::POS_W-1:0] index);
        deque_result_t r;
        int i;
        r.value = '0;
        r.found = 1'b0;
        r.where = '0;
        r.code  = bldq_pkg::ST_OK;
        unique case (kind)
            bldq_pkg::REQ_PUSH_FRONT:
                if (list_count >= bldq_pkg::DEPTH)
                    r.code = bldq_pkg::ST_FULL;
                else
                begin
                    list_head = (list_head + bldq_pkg::DEPTH - 1) % bldq_pkg::DEPTH;
                    list_store[list_head] = operand;
                    list_count++;
                    if (list_count == bldq_pkg::DEPTH)
                        full_visits++;
                end
            bldq_pkg::REQ_PUSH_BACK:
                if (list_count >= bldq_pkg::DEPTH)
                    r.code = bldq_pkg::ST_FULL;
                else
                begin
                    // tail always follows head + count, so an empty list needs no fix-up
                    list_store[ring_slot(list_count)] = operand;
                    list_count++;
                    if (list_count == bldq_pkg::DEPTH)
                        full_visits++;
                end
            bldq_pkg::REQ_POP_FRONT:
                if (list_count == 0)
                begin
                    r.code = bldq_pkg::ST_EMPTY;
                    empty_rejects++;
                end
                else
                begin
                    list_head = (list_head + 1) % bldq_pkg::DEPTH;
                    list_count--;
                end
            bldq_pkg::REQ_POP_BACK:
                if (list_count == 0)
                begin
                    r.code = bldq_pkg::ST_EMPTY;
                    empty_rejects++;
                end
                else
                    list_count--;
            bldq_pkg::REQ_CONTAINS:
                for (i = 0; i < list_count; i++)
                    if (list_store[ring_slot(i)] == operand)
                    begin
                        r.found = 1'b1;
                        break;
                    end
            bldq_pkg::REQ_READ:
                if (int'(index) >= list_count)
                    r.code = bldq_pkg::ST_BADIDX;
                else
                    r.value = list_store[ring_slot(int'(index))];
            bldq_pkg::REQ_WRITE:
                if (int'(index) >= list_count)
                    r.code = bldq_pkg::ST_BADIDX;
                else
                    list_store[ring_slot(int'(index))] = operand;
            bldq_pkg::REQ_FIRST_GT:
                for (i = 0; i < list_count; i++)
                    if (list_store[ring_slot(i)] > operand)
                    begin
                        r.found = 1'b1;
                        r.where = bldq_pkg::POS_W'(i);
                        break;
                    end
            bldq_pkg::REQ_CLEAR:
            begin
                list_count = 0;
                list_head  = 0;
            end
            default:
                ;
        endcase
        r.held = bldq_pkg::CNT_OUT_W'(list_count);
        return r;
    endfunction

    // mostly back to back, some short pauses, the odd long one
    function automatic int pick_gap();
        int r;
        if (steady_run)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic logic signed [bldq_pkg::VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return $urandom;
        if (r == 4)
            unique case ($urandom_range(0, 4))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                3: return -1;
                default: return 1;
            endcase
        if (r < 8 || list_count == 0)
            return int'($urandom_range(0, 16)) - 8;
        return list_store[ring_slot($urandom_range(0, list_count - 1))];
    endfunction

    function automatic logic [bldq_pkg::POS_W-1:0] pick_position();
        if (list_count > 0 && $urandom_range(0, 4) != 0)
            return bldq_pkg::POS_W'($urandom_range(0, list_count - 1));
        return bldq_pkg::POS_W'($urandom_range(0, bldq_pkg::DEPTH - 1));
    endfunction

    task automatic send_request(input logic [bldq_pkg::REQ_W-1:0] kind,
                                input logic signed [bldq_pkg::VAL_W-1:0] operand,
                                input logic [bldq_pkg::POS_W-1:0] index);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= kind;
        operand_value <= operand;
        position_in   <= index;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(apply_request(kind, operand, index));
        requests_sent++;
    endtask

    task automatic compare_field(input string field, input longint want_v, input longint got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want_v, got_v);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        deque_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing pending, count %0d status %0d",
                         $time, entry_count, status);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("read_value", want.value, read_value);
                compare_field("hit", want.found, hit);
                compare_field("position_out", want.where, position_out);
                compare_field("status", want.code, status);
                compare_field("entry_count", want.held, entry_count);
                results_checked++;
            end
        end
    end

    // result side back-pressure
    initial
    begin
        int hold;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            hold = pick_gap();
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Empty-list rejects, unused codes, both ends, reads, writes and searches on a short list.
    task automatic test_directed_edges();
        send_request(bldq_pkg::REQ_POP_FRONT, '0, '0);
        send_request(bldq_pkg::REQ_POP_BACK, '0, '0);
        send_request(bldq_pkg::REQ_READ, '0, '0);
        send_request(bldq_pkg::REQ_WRITE, VAL_MAX, '0);
        send_request(bldq_pkg::REQ_CONTAINS, '0, '0);
        send_request(bldq_pkg::REQ_FIRST_GT, VAL_MIN, '0);
        send_request(REQ_FIRST_UNUSED, VAL_MAX, 6'h3F);
        send_request(REQ_LAST_UNUSED, VAL_MIN, 6'h2A);
        send_request(bldq_pkg::REQ_PUSH_BACK, VAL_MIN, '0);     // push back onto empty list
        send_request(bldq_pkg::REQ_PUSH_FRONT, VAL_MAX, '0);
        send_request(bldq_pkg::REQ_PUSH_BACK, '0, '0);
        send_request(bldq_pkg::REQ_PUSH_FRONT, -1, '0);
        send_request(bldq_pkg::REQ_READ, '0, 6'd0);
        send_request(bldq_pkg::REQ_READ, '0, 6'd3);
        send_request(bldq_pkg::REQ_READ, '0, 6'd4);
        send_request(bldq_pkg::REQ_READ, '0, 6'h3F);
        send_request(bldq_pkg::REQ_WRITE, 32'sh5555_5555, 6'd1);
        send_request(bldq_pkg::REQ_WRITE, 32'shAAAA_AAAA, 6'd4);
        send_request(bldq_pkg::REQ_READ, '0, 6'd1);
        send_request(bldq_pkg::REQ_CONTAINS, VAL_MIN, '0);
        send_request(bldq_pkg::REQ_CONTAINS, 32'sh1234_5678, '0);
        send_request(bldq_pkg::REQ_FIRST_GT, VAL_MIN, '0);
        send_request(bldq_pkg::REQ_FIRST_GT, VAL_MAX, '0);
        send_request(bldq_pkg::REQ_POP_FRONT, '0, '0);
        send_request(bldq_pkg::REQ_POP_BACK, '0, '0);
        send_request(bldq_pkg::REQ_CLEAR, '0, '0);
        send_request(bldq_pkg::REQ_READ, '0, 6'd0);
    endtask

    // Fill the ring across the wrap point, hit it when full, search its far end, then drain.
    task automatic test_full_ring();
        int j;
        send_request(bldq_pkg::REQ_CLEAR, '0, '0);
        for (j = bldq_pkg::DEPTH / 2 - 1; j >= 0; j--)
            send_request(bldq_pkg::REQ_PUSH_FRONT, j * 1000 - 32000, '0);
        for (j = bldq_pkg::DEPTH / 2; j < bldq_pkg::DEPTH; j++)
            send_request(bldq_pkg::REQ_PUSH_BACK, j * 1000 - 32000, '0);
        send_request(bldq_pkg::REQ_PUSH_FRONT, VAL_MAX, '0);
        send_request(bldq_pkg::REQ_PUSH_BACK, VAL_MIN, '0);
        send_request(bldq_pkg::REQ_FIRST_GT, (bldq_pkg::DEPTH - 2) * 1000 - 32000, '0);
        send_request(bldq_pkg::REQ_FIRST_GT, (bldq_pkg::DEPTH - 1) * 1000 - 32000, '0);
        send_request(bldq_pkg::REQ_CONTAINS, (bldq_pkg::DEPTH - 1) * 1000 - 32000, '0);
        send_request(bldq_pkg::REQ_READ, '0, 6'h3F);
        send_request(bldq_pkg::REQ_WRITE, VAL_MIN, 6'h3F);
        send_request(bldq_pkg::REQ_READ, '0, 6'h3F);
        for (j = 0; j <= bldq_pkg::DEPTH; j++)
            send_request(j[0] ? bldq_pkg::REQ_POP_BACK : bldq_pkg::REQ_POP_FRONT, '0, '0);
    endtask

    // Mostly legal traffic that swings the list between empty and full, with some noise.
    task automatic test_random_mix(input int n_items);
        int n;
        int r;
        bit growing;
        logic [bldq_pkg::REQ_W-1:0] kind;
        growing = 1'b1;
        for (n = 0; n < n_items; n++)
        begin
            if (n % 100 == 0)
                steady_run = ((n / 100) % 3 == 2);
            if ((growing && list_count == bldq_pkg::DEPTH) || (!growing && list_count == 0))
            begin
                if ($urandom_range(0, 3) == 0)
                    growing = ~growing;
            end
            else if ($urandom_range(0, 99) == 0)
                growing = ~growing;
            r = $urandom_range(0, 99);
            if (r < 2)
                kind = bldq_pkg::REQ_W'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_UNUSED));
            else if (r == 2)
                kind = growing ? bldq_pkg::REQ_CONTAINS : bldq_pkg::REQ_CLEAR;
            else if (r < 45)
                kind = growing
                    ? (r[0] ? bldq_pkg::REQ_PUSH_FRONT : bldq_pkg::REQ_PUSH_BACK)
                    : (r[0] ? bldq_pkg::REQ_POP_FRONT : bldq_pkg::REQ_POP_BACK);
            else if (r < 60)
                kind = growing
                    ? (r[0] ? bldq_pkg::REQ_POP_FRONT : bldq_pkg::REQ_POP_BACK)
                    : (r[0] ? bldq_pkg::REQ_PUSH_FRONT : bldq_pkg::REQ_PUSH_BACK);
            else if (r < 70)
                kind = bldq_pkg::REQ_CONTAINS;
            else if (r < 80)
                kind = bldq_pkg::REQ_READ;
            else if (r < 90)
                kind = bldq_pkg::REQ_WRITE;
            else
                kind = bldq_pkg::REQ_FIRST_GT;
            send_request(kind, pick_value(), pick_position());
        end
        steady_run = 1'b0;
    endtask

    initial
    begin
        int k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_edges();
        test_full_ring();
        test_random_mix(1390);
        in_valid <= 1'b0;
        for (k = 0; k < 20000 && pending_results.size() != 0; k++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            error_count++;
        end
        $display("Sent %0d requests and compared %0d results, %0d errors.",
                 requests_sent, results_checked, error_count);
        $display("List filled %0d times, %0d pops rejected on an empty list.",
                 full_visits, empty_rejects);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/bldq_pkg.sv
rtl/bldq_ram.sv
rtl/bounded_list_deque_engine.sv
tb/testbench.sv
